// ===== rtl/aafc_pkg.sv =====
package aafc_pkg;

    localparam int COORD_W = 16;
    localparam int DIM_W = 13;
    localparam int COEF_W = 32;
    localparam int NCOEF = 6;
    localparam int DIFF_W = COORD_W + 1;
    localparam int SD_W = DIM_W + 1;
    localparam int DPROD_W = 2 * DIFF_W;
    localparam int DET_W = DPROD_W + 1;
    localparam int NAB_W = 31;
    localparam int CPROD_W = 48;
    localparam int NUM_W = 50;
    localparam int MAG_W = NUM_W - 1;
    localparam int UD_W = DET_W - 1;
    localparam int FRAC_W = 16;
    localparam int Q_W = 47;
    localparam int RES_W = Q_W + 1;
    localparam int CLAMP_SHIFT = 30;
    localparam int CLAMP_W = UD_W + CLAMP_SHIFT;
    localparam int DVD_W = MAG_W + FRAC_W + 1;
    localparam int ACC_W = 50;
    localparam int QDEPTH = 2;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [3:0][COORD_W-1:0] col;
        logic [3:0][COORD_W-1:0] row;
        logic [DIM_W-1:0]        width;
        logic [DIM_W-1:0]        height;
    } job_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL1,
        ST_SUM1,
        ST_MUL2,
        ST_SUM2,
        ST_START,
        ST_WAIT,
        ST_FINAL
    } state_t;

endpackage

// ===== rtl/aafc_front.sv =====
module aafc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [aafc_pkg::DIM_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [3:0][aafc_pkg::COORD_W-1:0] in_col,
    input  logic [3:0][aafc_pkg::COORD_W-1:0] in_row,
    output logic                          job_valid,
    input  logic                          job_pop,
    output aafc_pkg::job_t                job
);
    import aafc_pkg::*;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    job_t             entry_reg [QDEPTH];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;
    job_t             job_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_WIDTH)
                width_reg <= cfg_data;
            else
                height_reg <= cfg_data;
        end
    end

    // The corners are tagged with the extent in force when the beat arrives.
    always_comb
    begin
        job_in.col    = in_col;
        job_in.row    = in_row;
        job_in.width  = width_reg;
        job_in.height = height_reg;
    end

    assign in_stall  = (count_reg == 2'(QDEPTH));
    assign job_valid = (count_reg != 2'd0);
    assign push      = in_valid && !in_stall;
    assign pop       = job_pop && job_valid;
    assign job       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= job_in;
    end

endmodule

// ===== rtl/aafc_div.sv =====
module aafc_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [aafc_pkg::NUM_W-1:0]   num,
    input  logic signed [aafc_pkg::DET_W-1:0]   den,
    output logic                                done,
    output logic signed [aafc_pkg::RES_W-1:0]   quot
);
    import aafc_pkg::*;

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [NUM_W-1:0]   un_full;
    logic [DET_W-1:0]   ud_full;
    logic [MAG_W-1:0]   un;
    logic [UD_W-1:0]    ud;
    logic [DVD_W-1:0]   dividend;
    logic [UD_W+1:0]    trial;
    logic               ge;
    logic [Q_W-1:0]     mag;

    logic [UD_W-1:0]    ud_reg;
    logic [UD_W-1:0]    rem_reg;
    logic [Q_W-1:0]     low_reg;
    logic               neg_reg;
    logic               clamp_reg;
    logic               run_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;

    assign un_full  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign ud_full  = den[DET_W-1] ? DET_W'(-den) : DET_W'(den);
    assign un       = un_full[MAG_W-1:0];
    assign ud       = ud_full[UD_W-1:0];
    // Rounding is folded in by adding half the divisor before dividing.
    assign dividend = DVD_W'({un, FRAC_W'(0)}) + DVD_W'(ud >> 1);

    assign trial = {1'b0, rem_reg, low_reg[Q_W-1]} - {2'b00, ud_reg};
    assign ge    = !trial[UD_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(Q_W);
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ud_reg    <= ud;
            neg_reg   <= num[NUM_W-1] ^ den[DET_W-1];
            clamp_reg <= CLAMP_W'(un) >= (CLAMP_W'(ud) << CLAMP_SHIFT);
            rem_reg   <= UD_W'(dividend[DVD_W-1:Q_W]);
            low_reg   <= dividend[Q_W-1:0];
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? trial[UD_W-1:0] : {rem_reg[UD_W-2:0], low_reg[Q_W-1]};
            low_reg <= {low_reg[Q_W-2:0], ge};
        end
    end

    assign mag  = clamp_reg ? (Q_W'(1) << (Q_W - 1)) : low_reg;
    assign quot = neg_reg ? -$signed(RES_W'(mag)) : $signed(RES_W'(mag));
    assign done = done_reg;

endmodule

// ===== rtl/aafc_back.sv =====
module aafc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    output logic                          job_pop,
    input  aafc_pkg::job_t                job,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [aafc_pkg::NCOEF-1:0][aafc_pkg::COEF_W-1:0] coef,
    output logic                          degenerate
);
    import aafc_pkg::*;

    state_t state_reg;
    state_t state_next;

    job_t   job_reg;
    logic [1:0] tri_reg;
    logic   degen_reg;

    logic [COORD_W-1:0] cp, cq, cr, rp, rq, rr;
    logic [DIM_W-1:0]   up, uq, ur, vp, vq, vr;

    logic signed [DIFF_W-1:0] dxq_reg, dyq_reg, dxr_reg, dyr_reg;
    logic [COORD_W-1:0]       px_reg, py_reg;
    logic signed [SD_W-1:0]   sq_reg [2];
    logic signed [SD_W-1:0]   sr_reg [2];
    logic [DIM_W-1:0]         dp_reg [2];

    logic signed [DPROD_W-1:0] md0_reg, md1_reg;
    logic signed [NAB_W-1:0]   pa0_reg [2];
    logic signed [NAB_W-1:0]   pa1_reg [2];
    logic signed [NAB_W-1:0]   pb0_reg [2];
    logic signed [NAB_W-1:0]   pb1_reg [2];

    logic signed [DET_W-1:0]   det_reg;
    logic signed [NAB_W-1:0]   na_reg [2];
    logic signed [NAB_W-1:0]   nb_reg [2];

    logic signed [CPROD_W-1:0] c0_reg [2];
    logic signed [CPROD_W-1:0] c1_reg [2];
    logic signed [CPROD_W-1:0] c2_reg [2];
    logic signed [NUM_W-1:0]   nc_reg [2];

    logic                      div_start;
    logic [NCOEF-1:0]          div_done;
    logic signed [NUM_W-1:0]   div_num [NCOEF];
    logic signed [RES_W-1:0]   div_quot [NCOEF];
    logic signed [ACC_W-1:0]   acc_reg [NCOEF];

    logic                      out_valid_reg;
    logic [NCOEF-1:0][COEF_W-1:0] coef_reg;
    logic                      degenerate_reg;
    logic                      out_free;

    function automatic logic [COEF_W-1:0] finish(input logic signed [ACC_W-1:0] s);
        logic [ACC_W-1:0]        m;
        logic [ACC_W-1:0]        q;
        logic signed [ACC_W-1:0] v;
        m = s[ACC_W-1] ? ACC_W'(-s) : ACC_W'(s);
        q = (m + ACC_W'(2)) >> 2;
        v = s[ACC_W-1] ? -$signed(q) : $signed(q);
        if (v > $signed(ACC_W'(32'h7fff_ffff)))
            return 32'h7fff_ffff;
        else if (v < -$signed(ACC_W'(33'h0_8000_0000)))
            return 32'h8000_0000;
        else
            return v[COEF_W-1:0];
    endfunction

    assign out_free = !out_valid_reg || !out_stall;

    // Corner triples with one corner left out each, in fixed order.
    always_comb
    begin
        unique case (tri_reg)
            2'd0:
            begin
                cp = job_reg.col[0]; cq = job_reg.col[1]; cr = job_reg.col[2];
                rp = job_reg.row[0]; rq = job_reg.row[1]; rr = job_reg.row[2];
                up = '0; uq = '0; ur = job_reg.width;
                vp = '0; vq = job_reg.height; vr = '0;
            end
            2'd1:
            begin
                cp = job_reg.col[0]; cq = job_reg.col[1]; cr = job_reg.col[3];
                rp = job_reg.row[0]; rq = job_reg.row[1]; rr = job_reg.row[3];
                up = '0; uq = '0; ur = job_reg.width;
                vp = '0; vq = job_reg.height; vr = job_reg.height;
            end
            2'd2:
            begin
                cp = job_reg.col[0]; cq = job_reg.col[2]; cr = job_reg.col[3];
                rp = job_reg.row[0]; rq = job_reg.row[2]; rr = job_reg.row[3];
                up = '0; uq = job_reg.width; ur = job_reg.width;
                vp = '0; vq = '0; vr = job_reg.height;
            end
            default:
            begin
                cp = job_reg.col[1]; cq = job_reg.col[2]; cr = job_reg.col[3];
                rp = job_reg.row[1]; rq = job_reg.row[2]; rr = job_reg.row[3];
                up = '0; uq = job_reg.width; ur = job_reg.width;
                vp = job_reg.height; vq = '0; vr = job_reg.height;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        job_pop    = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:  state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_SUM1;
            ST_SUM1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = (det_reg == '0) ? ST_FINAL : ST_SUM2;
            ST_SUM2:  state_next = ST_START;
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (&div_done)
                    state_next = (tri_reg == 2'd3) ? ST_FINAL : ST_DIFF;
            end
            ST_FINAL:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && job_valid)
        begin
            job_reg   <= job;
            tri_reg   <= 2'd0;
            degen_reg <= 1'b0;
            for (int j = 0; j < NCOEF; j++)
                acc_reg[j] <= '0;
        end
        if (state_reg == ST_DIFF)
        begin
            dxq_reg <= $signed({1'b0, cq}) - $signed({1'b0, cp});
            dyq_reg <= $signed({1'b0, rq}) - $signed({1'b0, rp});
            dxr_reg <= $signed({1'b0, cr}) - $signed({1'b0, cp});
            dyr_reg <= $signed({1'b0, rr}) - $signed({1'b0, rp});
            px_reg  <= cp;
            py_reg  <= rp;
            sq_reg[0] <= $signed({1'b0, uq}) - $signed({1'b0, up});
            sr_reg[0] <= $signed({1'b0, ur}) - $signed({1'b0, up});
            sq_reg[1] <= $signed({1'b0, vq}) - $signed({1'b0, vp});
            sr_reg[1] <= $signed({1'b0, vr}) - $signed({1'b0, vp});
            dp_reg[0] <= up;
            dp_reg[1] <= vp;
        end
        if (state_reg == ST_MUL1)
        begin
            md0_reg <= DPROD_W'(dxq_reg) * DPROD_W'(dyr_reg);
            md1_reg <= DPROD_W'(dxr_reg) * DPROD_W'(dyq_reg);
            for (int k = 0; k < 2; k++)
            begin
                pa0_reg[k] <= NAB_W'(sq_reg[k]) * NAB_W'(dyr_reg);
                pa1_reg[k] <= NAB_W'(sr_reg[k]) * NAB_W'(dyq_reg);
                pb0_reg[k] <= NAB_W'(dxq_reg) * NAB_W'(sr_reg[k]);
                pb1_reg[k] <= NAB_W'(dxr_reg) * NAB_W'(sq_reg[k]);
            end
        end
        if (state_reg == ST_SUM1)
        begin
            det_reg <= DET_W'(md0_reg) - DET_W'(md1_reg);
            for (int k = 0; k < 2; k++)
            begin
                na_reg[k] <= pa0_reg[k] - pa1_reg[k];
                nb_reg[k] <= pb0_reg[k] - pb1_reg[k];
            end
        end
        if (state_reg == ST_MUL2)
        begin
            if (det_reg == '0)
                degen_reg <= 1'b1;
            for (int k = 0; k < 2; k++)
            begin
                c0_reg[k] <= CPROD_W'($signed({1'b0, dp_reg[k]})) * CPROD_W'(det_reg);
                c1_reg[k] <= CPROD_W'(na_reg[k]) * CPROD_W'($signed({1'b0, px_reg}));
                c2_reg[k] <= CPROD_W'(nb_reg[k]) * CPROD_W'($signed({1'b0, py_reg}));
            end
        end
        if (state_reg == ST_SUM2)
        begin
            for (int k = 0; k < 2; k++)
                nc_reg[k] <= NUM_W'(c0_reg[k]) - NUM_W'(c1_reg[k]) - NUM_W'(c2_reg[k]);
        end
        if (state_reg == ST_WAIT && (&div_done))
        begin
            for (int j = 0; j < NCOEF; j++)
                acc_reg[j] <= acc_reg[j] + ACC_W'(div_quot[j]);
            tri_reg <= tri_reg + 2'd1;
        end
    end

    // Lane order a, b, c for u then d, e, f for v; gains carry the Q12.4 scale.
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            div_num[3*k]     = NUM_W'(na_reg[k]) <<< 4;
            div_num[3*k + 1] = NUM_W'(nb_reg[k]) <<< 4;
            div_num[3*k + 2] = nc_reg[k];
        end
    end

    for (genvar g = 0; g < NCOEF; g++)
    begin : g_div
        aafc_div u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .start (div_start),
            .num   (div_num[g]),
            .den   (det_reg),
            .done  (div_done[g]),
            .quot  (div_quot[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_FINAL && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINAL && out_free)
        begin
            degenerate_reg <= degen_reg;
            for (int j = 0; j < NCOEF; j++)
                coef_reg[j] <= degen_reg ? '0 : finish(acc_reg[j]);
        end
    end

    assign out_valid  = out_valid_reg;
    assign coef       = coef_reg;
    assign degenerate = degenerate_reg;

endmodule

// ===== rtl/averaged_affine_fit_four_corners.sv =====
// Averaged affine fit of a quadrilateral onto a W x H target rectangle.
// Input channel: one beat carries the four corners (Q12.4 pixels) on
// in_valid / in_stall. Output channel: one beat carries coef_a..coef_f
// (signed Q16.16) and degenerate on out_valid / out_stall.
// Configuration: cfg_write with cfg_index 0 sets the width, 1 the height;
// write only while the block is idle.
// A two-entry queue sits behind the input, so up to two corner sets are
// taken while the solver is busy or the output is held.
// Per corner triple the solver steps through diff, mul1, sum1, mul2 and
// sum2 for the products and sums, a start state that launches the six
// bit-serial dividers running side by side and a wait state until all are
// done; one state takes the set from the queue and one registers the result.
// A collinear triple ends the set early. The solver works on one set at a
// time and takes the next from the queue only once the result is registered.
// While out_stall is high the finished result is held and the solver waits
// to register the next one; the queue keeps taking beats until it is full.
// Reset empties the queue and the output and sets W and H to 256.
module averaged_affine_fit_four_corners (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic                               cfg_index,
    input  logic [aafc_pkg::DIM_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [aafc_pkg::COORD_W-1:0]       top_left_col,
    input  logic [aafc_pkg::COORD_W-1:0]       top_left_row,
    input  logic [aafc_pkg::COORD_W-1:0]       bottom_left_col,
    input  logic [aafc_pkg::COORD_W-1:0]       bottom_left_row,
    input  logic [aafc_pkg::COORD_W-1:0]       top_right_col,
    input  logic [aafc_pkg::COORD_W-1:0]       top_right_row,
    input  logic [aafc_pkg::COORD_W-1:0]       bottom_right_col,
    input  logic [aafc_pkg::COORD_W-1:0]       bottom_right_row,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [aafc_pkg::COEF_W-1:0] coef_a,
    output logic signed [aafc_pkg::COEF_W-1:0] coef_b,
    output logic signed [aafc_pkg::COEF_W-1:0] coef_c,
    output logic signed [aafc_pkg::COEF_W-1:0] coef_d,
    output logic signed [aafc_pkg::COEF_W-1:0] coef_e,
    output logic signed [aafc_pkg::COEF_W-1:0] coef_f,
    output logic                               degenerate
);
    import aafc_pkg::*;

    logic [3:0][COORD_W-1:0] in_col;
    logic [3:0][COORD_W-1:0] in_row;
    logic                    job_valid;
    logic                    job_pop;
    job_t                    job;
    logic [NCOEF-1:0][COEF_W-1:0] coef;

    assign in_col = {bottom_right_col, top_right_col, bottom_left_col, top_left_col};
    assign in_row = {bottom_right_row, top_right_row, bottom_left_row, top_left_row};

    aafc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_col    (in_col),
        .in_row    (in_row),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job)
    );

    aafc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job_pop    (job_pop),
        .job        (job),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .coef       (coef),
        .degenerate (degenerate)
    );

    assign coef_a = $signed(coef[0]);
    assign coef_b = $signed(coef[1]);
    assign coef_c = $signed(coef[2]);
    assign coef_d = $signed(coef[3]);
    assign coef_e = $signed(coef[4]);
    assign coef_f = $signed(coef[5]);

endmodule
